// ===== sv/tcs_pkg.sv =====
`timescale 1ns / 1ps

package tcs_pkg;

   localparam int NUM_UNITS  = 16;
   localparam int UNIT_W     = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PICKUP = 2'd0,
      OP_HANGUP = 2'd1,
      OP_DIAL   = 2'd2,
      OP_CHAT   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ON_HOOK   = 3'd0,
      ST_RINGING   = 3'd1,
      ST_DIAL_TONE = 3'd2,
      ST_RING_BACK = 3'd3,
      ST_BUSY      = 3'd4,
      ST_CONNECTED = 3'd5,
      ST_ERROR     = 3'd6
   } call_state_type;

   typedef struct packed {
      call_state_type     state;
      logic               linked;
      logic [UNIT_W-1:0]  idx;
   } entry_type;

   typedef struct packed {
      logic               we_state;
      call_state_type     state;
      logic               we_link;
      logic               linked;
      logic [UNIT_W-1:0]  idx;
      logic [UNIT_W-1:0]  addr;
   } wr_type;

   typedef struct packed {
      logic [3:0] notify_unit;
      logic [2:0] notify_state;
      logic       status;
      logic       last;
   } rsp_item_type;

endpackage

// ===== sv/tcs_if.sv =====
`timescale 1ns / 1ps

interface tcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [3:0] unit;
   logic [3:0] target;
   logic       target_found;

   modport source (output valid, output op, output unit, output target,
                   output target_found, input ready);
   modport sink   (input valid, input op, input unit, input target,
                   input target_found, output ready);
endinterface

interface tcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] notify_unit;
   logic [2:0] notify_state;
   logic       status;
   logic       last;

   modport source (output valid, output notify_unit, output notify_state,
                   output status, output last, input ready);
   modport sink   (input valid, input notify_unit, input notify_state,
                   input status, input last, output ready);
endinterface

// ===== sv/tcs_table.sv =====
`timescale 1ns / 1ps

module tcs_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcs_pkg::UNIT_W-1:0]    rd_a_addr,
   input  logic [tcs_pkg::UNIT_W-1:0]    rd_b_addr,
   output tcs_pkg::entry_type            rd_a,
   output tcs_pkg::entry_type            rd_b,
   input  tcs_pkg::wr_type               wr_a,
   input  tcs_pkg::wr_type               wr_b
);

   tcs_pkg::entry_type tab_ff [tcs_pkg::NUM_UNITS];
   tcs_pkg::entry_type tab_in [tcs_pkg::NUM_UNITS];

   assign rd_a = tab_ff[rd_a_addr];
   assign rd_b = tab_ff[rd_b_addr];

   // peer write first, own unit write wins
   always_comb begin
      tab_in = tab_ff;
      if (wr_b.we_state) begin
         tab_in[wr_b.addr].state = wr_b.state;
      end
      if (wr_b.we_link) begin
         tab_in[wr_b.addr].linked = wr_b.linked;
         tab_in[wr_b.addr].idx    = wr_b.idx;
      end
      if (wr_a.we_state) begin
         tab_in[wr_a.addr].state = wr_a.state;
      end
      if (wr_a.we_link) begin
         tab_in[wr_a.addr].linked = wr_a.linked;
         tab_in[wr_a.addr].idx    = wr_a.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcs_pkg::NUM_UNITS; i++) begin
            tab_ff[i] <= '{state: tcs_pkg::ST_ON_HOOK, linked: 1'b0, idx: '0};
         end
      end else begin
         tab_ff <= tab_in;
      end
   end

endmodule

// ===== sv/tcs_fifo.sv =====
`timescale 1ns / 1ps

module tcs_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push0_valid,
   input  tcs_pkg::rsp_item_type push0,
   input  logic                  push1_valid,
   input  tcs_pkg::rsp_item_type push1,
   output logic                  room,
   tcs_rsp_if.source             rsp
);

   tcs_pkg::rsp_item_type        mem_ff [tcs_pkg::FIFO_DEPTH];
   logic [tcs_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [tcs_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [tcs_pkg::PTR_W-1:0]    tail, tail1;
   logic                         pop;
   tcs_pkg::rsp_item_type        head_item;

   assign pop       = rsp.valid && rsp.ready;
   assign room      = count_ff <= tcs_pkg::CNT_W'(tcs_pkg::FIFO_DEPTH - 2);
   assign tail      = head_ff + count_ff[tcs_pkg::PTR_W-1:0];
   assign tail1     = push0_valid ? tail + tcs_pkg::PTR_W'(1) : tail;
   assign head_item = mem_ff[head_ff];

   assign rsp.valid        = count_ff != '0;
   assign rsp.notify_unit  = head_item.notify_unit;
   assign rsp.notify_state = head_item.notify_state;
   assign rsp.status       = head_item.status;
   assign rsp.last         = head_item.last;

   always_comb begin
      head_in  = pop ? head_ff + tcs_pkg::PTR_W'(1) : head_ff;
      count_in = count_ff - tcs_pkg::CNT_W'(pop) + tcs_pkg::CNT_W'(push0_valid)
                 + tcs_pkg::CNT_W'(push1_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0_valid) begin
         mem_ff[tail] <= push0;
      end
      if (push1_valid) begin
         mem_ff[tail1] <= push1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tcs_pkg::CNT_W'(tcs_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push0_valid || push1_valid) |-> room)
      else $error("push without room");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push0_valid && !push1_valid) |=>
         count_ff == $past(count_ff) - tcs_pkg::CNT_W'(1))
      else $error("pop did not drain one item");

endmodule

// ===== sv/telephone_unit_call_state_table_core.sv =====
`timescale 1ns / 1ps

// Call state table for sixteen telephone units. Each request item is one
// event (pickup, hangup, dial, chat) for one unit; the block answers with
// the changed peer state first, if any, then the unit's own state with
// last set. An item is taken into an input register and resolved, once
// the queue has room, against a flip-flop register file, its one or two
// notifications going into a four-entry result queue that feeds the
// result channel. A new item is taken every cycle while the queue has
// room for two notifications; since the result channel drains one
// notification a cycle while the consumer is ready, events with two
// notifications are taken more slowly than that, all others one a cycle.
// Reset clears every unit to on hook with no peer.
module telephone_unit_call_state_table_core (
   input  logic      clock,
   input  logic      reset,
   tcs_req_if.sink   req,
   tcs_rsp_if.source rsp
);

   localparam logic [tcs_pkg::UNIT_W:0] NUM_LIM = (tcs_pkg::UNIT_W+1)'(tcs_pkg::NUM_UNITS);

   logic                        in_valid_ff, in_valid_in;
   tcs_pkg::op_type             op_ff;
   logic [tcs_pkg::UNIT_W-1:0]  unit_ff, target_ff;
   logic                        found_ff;

   logic                        accept, fire, room, unit_ok, peer_ok, target_ok;
   tcs_pkg::entry_type          own, tgt;
   tcs_pkg::wr_type             wr_a, wr_b;
   logic                        r0_valid;
   tcs_pkg::rsp_item_type       r0, r1;
   tcs_pkg::call_state_type     own_new;

   assign accept      = req.valid && req.ready;
   assign fire        = in_valid_ff && room;
   assign req.ready   = !in_valid_ff || fire;
   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= tcs_pkg::op_type'(req.op);
         unit_ff   <= req.unit;
         target_ff <= req.target;
         found_ff  <= req.target_found;
      end
   end

   tcs_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (unit_ff),
      .rd_b_addr (target_ff),
      .rd_a      (own),
      .rd_b      (tgt),
      .wr_a      (wr_a),
      .wr_b      (wr_b)
   );

   assign unit_ok   = {1'b0, unit_ff} < NUM_LIM;
   assign target_ok = {1'b0, target_ff} < NUM_LIM;
   assign peer_ok   = own.linked && ({1'b0, own.idx} < NUM_LIM);

   always_comb begin
      wr_a     = '{we_state: 1'b0, state: tcs_pkg::ST_ON_HOOK, we_link: 1'b0,
                   linked: 1'b0, idx: '0, addr: unit_ff};
      wr_b     = '{we_state: 1'b0, state: tcs_pkg::ST_ON_HOOK, we_link: 1'b0,
                   linked: 1'b0, idx: '0, addr: own.idx};
      r0_valid = 1'b0;
      r0       = '0;
      r1       = '0;
      own_new  = own.state;
      case (op_ff)
         tcs_pkg::OP_PICKUP: begin
            if (own.state == tcs_pkg::ST_ON_HOOK) begin
               own_new = tcs_pkg::ST_DIAL_TONE;
            end else if (own.state == tcs_pkg::ST_RINGING) begin
               own_new = tcs_pkg::ST_CONNECTED;
               if (peer_ok) begin
                  wr_b.we_state = 1'b1;
                  wr_b.state    = tcs_pkg::ST_CONNECTED;
                  r0_valid      = 1'b1;
               end
            end
         end
         tcs_pkg::OP_HANGUP: begin
            own_new = tcs_pkg::ST_ON_HOOK;
            if (own.state inside {tcs_pkg::ST_CONNECTED, tcs_pkg::ST_RINGING,
                                  tcs_pkg::ST_RING_BACK}) begin
               wr_a.we_link = 1'b1;
               if (peer_ok) begin
                  wr_b.we_state = 1'b1;
                  wr_b.state    = (own.state == tcs_pkg::ST_RING_BACK) ?
                                  tcs_pkg::ST_ON_HOOK : tcs_pkg::ST_DIAL_TONE;
                  wr_b.we_link  = 1'b1;
                  r0_valid      = 1'b1;
               end
            end
         end
         tcs_pkg::OP_DIAL: begin
            if (own.state == tcs_pkg::ST_DIAL_TONE) begin
               if (!found_ff || !target_ok) begin
                  own_new = tcs_pkg::ST_ERROR;
               end else if (target_ff == unit_ff || tgt.linked ||
                            tgt.state != tcs_pkg::ST_ON_HOOK) begin
                  own_new = tcs_pkg::ST_BUSY;
               end else begin
                  own_new       = tcs_pkg::ST_RING_BACK;
                  wr_a.we_link  = 1'b1;
                  wr_a.linked   = 1'b1;
                  wr_a.idx      = target_ff;
                  wr_b.addr     = target_ff;
                  wr_b.we_state = 1'b1;
                  wr_b.state    = tcs_pkg::ST_RINGING;
                  wr_b.we_link  = 1'b1;
                  wr_b.linked   = 1'b1;
                  wr_b.idx      = unit_ff;
                  r0_valid      = 1'b1;
               end
            end
         end
         tcs_pkg::OP_CHAT: begin
            r1.status = own.state != tcs_pkg::ST_CONNECTED;
         end
         default: begin
            own_new = own.state;
         end
      endcase
      wr_a.we_state = own_new != own.state;
      wr_a.state    = own_new;
      r0.notify_unit  = 4'(wr_b.addr);
      r0.notify_state = wr_b.state;
      r1.notify_unit  = 4'(unit_ff);
      r1.notify_state = own_new;
      r1.last         = 1'b1;
      if (!(fire && unit_ok)) begin
         wr_a.we_state = 1'b0;
         wr_a.we_link  = 1'b0;
         wr_b.we_state = 1'b0;
         wr_b.we_link  = 1'b0;
         r0_valid      = 1'b0;
      end
   end

   tcs_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push0_valid (r0_valid),
      .push0       (r0),
      .push1_valid (fire && unit_ok),
      .push1       (r1),
      .room        (room),
      .rsp         (rsp)
   );

   a_peer_not_self: assert property (@(posedge clock) disable iff (reset)
      r0_valid |-> (r0.notify_unit != 4'(unit_ff)))
      else $error("peer notification names the acting unit");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      fire |=> (!in_valid_ff || $past(accept)))
      else $error("input register kept a resolved item");

endmodule
